// File: hdl/fwcp_pkg.sv
package fwcp_pkg;

  localparam int MAX_HALF_DEF   = 8;
  localparam int INDEX_BITS_DEF = 20;

  localparam int HALF_W  = 4;
  localparam int HYST_W  = 20;
  localparam int TOTAL_W = 21;
  localparam int FRAME_W = 20;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 2'd2;

  localparam logic [HALF_W-1:0]  HALF_WINDOW_RST  = 4'd8;
  localparam logic [HYST_W-1:0]  HYSTERESIS_RST   = '0;
  localparam logic [TOTAL_W-1:0] TOTAL_FRAMES_RST = '0;

endpackage

// File: hdl/frame_window_cache_policy.sv
// Sliding-window frame cache policy.
// The input channel (in_valid_i / in_ready_o) takes one requested frame
// index per item. The block then produces a train of result items on the
// output channel (out_valid_o / out_ready_i): one lookup reply that tells
// whether the frame was cached, then evict commands in ascending frame
// order, then load commands from the window center upward and then from
// the window's low end up to the center. The final item of a request has
// last_o set. The configuration channel (cfg_valid_i / cfg_ready_o) is
// always ready. The user must write it only while no request is in
// progress; the block itself does not enforce this. A request is handled
// by a small sequencer that visits one presence bit or one candidate frame
// per cycle unless the receiver stalls: two setup steps, a scan of all
// 2*MAX_HALF+1 presence bits, the load steps and one closing step. The
// next request is taken only once the last item of the previous one has
// moved into the output register. When the receiver stalls, the sequencer
// holds at the next item it has to send. Reset empties the cache, forgets
// the window center and returns the registers to their reset values.
module frame_window_cache_policy
  import fwcp_pkg::*;
#(
  parameter int MAX_HALF   = MAX_HALF_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [INDEX_BITS-1:0] requested_frame_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [KIND_W-1:0]     kind_o,
  output logic [FRAME_W-1:0]    frame_index_o,
  output logic                  hit_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int MB = 2 * MAX_HALF + 1;
  localparam int MW = $clog2(MB);
  localparam int IB = INDEX_BITS;
  localparam int FW = IB + 1;
  localparam int LW = (IB + 2 > 22) ? IB + 2 : 22;
  localparam logic [MW-1:0]     K_LAST   = MW'(MB - 1);
  localparam logic [MW-1:0]     J_CENTER = MW'(MAX_HALF);
  localparam logic [HALF_W-1:0] H_MAX    = HALF_W'(MAX_HALF);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LOOKUP  = 3'd1;
  localparam logic [2:0] ST_BOUNDS  = 3'd2;
  localparam logic [2:0] ST_EVICT   = 3'd3;
  localparam logic [2:0] ST_LOAD_HI = 3'd4;
  localparam logic [2:0] ST_LOAD_LO = 3'd5;
  localparam logic [2:0] ST_FLUSH   = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [HALF_W-1:0]   half_q;
  logic [HYST_W-1:0]   hyst_q;
  logic [TOTAL_W-1:0]  total_q;
  logic                set_q;
  logic [IB-1:0]       center_q;
  logic [MB-1:0]       mask_q;
  logic [MB-1:0]       newmask_q;
  logic [IB-1:0]       req_q;
  logic [IB-1:0]       newc_q;
  logic [IB-1:0]       lo_q;
  logic [FW-1:0]       hi_q;
  logic [FW-1:0]       fbase_q;
  logic [MW-1:0]       rel_q;
  logic [MW-1:0]       jlo_q;
  logic [MW-1:0]       k_q;
  logic [MW-1:0]       j_q;
  logic [FW-1:0]       f_q;

  logic                pend_valid_q;
  logic [KIND_W-1:0]   pend_kind_q;
  logic [FRAME_W-1:0]  pend_frame_q;
  logic                pend_hit_q;
  logic                out_valid_q;
  logic [KIND_W-1:0]   out_kind_q;
  logic [FRAME_W-1:0]  out_frame_q;
  logic                out_hit_q;
  logic                out_last_q;

  logic [HALF_W-1:0]   h;
  logic signed [LW-1:0] diff;
  logic [LW-1:0]       distance;
  logic                near;
  logic [MW-1:0]       hit_off;
  logic [IB-1:0]       newc_calc;
  logic [FW-1:0]       fe;
  logic                outside;
  logic [MW-1:0]       keep_off;
  logic                hi_go;
  logic                lo_go;
  logic                out_free;
  logic                emit_ok;
  logic                emit_req;
  logic [KIND_W-1:0]   emit_kind;
  logic [FRAME_W-1:0]  emit_frame;
  logic                emit_hit;
  logic                step_en;
  logic                flush_go;
  logic                out_load;
  logic [HALF_W-1:0]   down_span;

  assign h = (half_q > H_MAX) ? H_MAX : half_q;

  assign diff = $signed(LW'(req_q)) - $signed(LW'(center_q));
  assign distance = diff[LW-1] ? LW'(-diff) : LW'(diff);
  assign near = (diff >= -$signed(LW'(MAX_HALF))) && (diff <= $signed(LW'(MAX_HALF)));
  assign hit_off = MW'(diff) + J_CENTER;

  always_comb begin
    newc_calc = center_q;
    if (!set_q || (distance > LW'(hyst_q))) begin
      newc_calc = req_q;
    end
  end

  assign down_span = (newc_q < IB'(h)) ? HALF_W'(newc_q) : h;

  assign fe       = fbase_q + FW'(k_q);
  assign outside  = (fe < FW'(lo_q)) || (fe > hi_q);
  assign keep_off = k_q + rel_q;
  assign hi_go    = (f_q <= hi_q) && (LW'(f_q) < LW'(total_q)) && !f_q[IB];
  assign lo_go    = (f_q < FW'(newc_q)) && (LW'(f_q) < LW'(total_q));

  assign out_free = !out_valid_q || out_ready_i;
  assign emit_ok  = !pend_valid_q || out_free;

  always_comb begin
    emit_req   = 1'b0;
    emit_kind  = KIND_LOOKUP;
    emit_frame = FRAME_W'(LW'(req_q));
    emit_hit   = 1'b0;
    case (state_q)
      ST_LOOKUP: begin
        emit_req = 1'b1;
        emit_hit = near && mask_q[hit_off];
      end
      ST_EVICT: begin
        emit_req   = mask_q[k_q] && outside;
        emit_kind  = KIND_EVICT;
        emit_frame = FRAME_W'(LW'(fe));
      end
      ST_LOAD_HI: begin
        emit_req   = hi_go && !newmask_q[j_q];
        emit_kind  = KIND_LOAD;
        emit_frame = FRAME_W'(LW'(f_q));
      end
      ST_LOAD_LO: begin
        emit_req   = lo_go && !newmask_q[j_q];
        emit_kind  = KIND_LOAD;
        emit_frame = FRAME_W'(LW'(f_q));
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign step_en  = !emit_req || emit_ok;
  assign flush_go = (state_q == ST_FLUSH) && out_free;
  assign out_load = (emit_req && emit_ok && pend_valid_q) || flush_go;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_d = ST_BOUNDS;
      ST_BOUNDS: state_d = ST_EVICT;
      ST_EVICT: begin
        if (step_en && (k_q == K_LAST)) begin
          state_d = ST_LOAD_HI;
        end
      end
      ST_LOAD_HI: begin
        if (!hi_go) begin
          state_d = ST_LOAD_LO;
        end
      end
      ST_LOAD_LO: begin
        if (!lo_go) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      half_q       <= HALF_WINDOW_RST;
      hyst_q       <= HYSTERESIS_RST;
      total_q      <= TOTAL_FRAMES_RST;
      set_q        <= 1'b0;
      center_q     <= '0;
      mask_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_HALF_WINDOW:  half_q  <= cfg_data_i[HALF_W-1:0];
          CFG_HYSTERESIS:   hyst_q  <= cfg_data_i[HYST_W-1:0];
          CFG_TOTAL_FRAMES: total_q <= cfg_data_i[TOTAL_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_q == ST_LOOKUP) begin
        set_q <= 1'b1;
      end
      if ((state_q == ST_LOAD_LO) && !lo_go) begin
        center_q <= newc_q;
        mask_q   <= newmask_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit_req && emit_ok) begin
        pend_valid_q <= 1'b1;
      end
      if (flush_go) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      req_q <= requested_frame_i;
    end
    if (state_q == ST_LOOKUP) begin
      newc_q <= newc_calc;
    end
    if (state_q == ST_BOUNDS) begin
      lo_q      <= (newc_q >= IB'(h)) ? newc_q - IB'(h) : '0;
      hi_q      <= FW'(newc_q) + FW'(h);
      fbase_q   <= FW'(center_q) - FW'(MAX_HALF);
      rel_q     <= MW'(center_q) - MW'(newc_q);
      jlo_q     <= J_CENTER - MW'(down_span);
      k_q       <= '0;
      newmask_q <= '0;
    end
    if ((state_q == ST_EVICT) && step_en) begin
      k_q <= k_q + MW'(1);
      if (mask_q[k_q] && !outside) begin
        newmask_q[keep_off] <= 1'b1;
      end
      if (k_q == K_LAST) begin
        f_q <= FW'(newc_q);
        j_q <= J_CENTER;
      end
    end
    if ((state_q == ST_LOAD_HI) || (state_q == ST_LOAD_LO)) begin
      if ((state_q == ST_LOAD_HI) ? hi_go : lo_go) begin
        if (step_en) begin
          newmask_q[j_q] <= 1'b1;
          f_q <= f_q + FW'(1);
          j_q <= j_q + MW'(1);
        end
      end else if (state_q == ST_LOAD_HI) begin
        f_q <= FW'(lo_q);
        j_q <= jlo_q;
      end
    end
    if (emit_req && emit_ok) begin
      pend_kind_q  <= emit_kind;
      pend_frame_q <= emit_frame;
      pend_hit_q   <= emit_hit;
      if (pend_valid_q) begin
        out_kind_q  <= pend_kind_q;
        out_frame_q <= pend_frame_q;
        out_hit_q   <= pend_hit_q;
        out_last_q  <= 1'b0;
      end
    end
    if (flush_go) begin
      out_kind_q  <= pend_kind_q;
      out_frame_q <= pend_frame_q;
      out_hit_q   <= pend_hit_q;
      out_last_q  <= 1'b1;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign frame_index_o = out_frame_q;
  assign hit_o         = out_hit_q;
  assign last_o        = out_last_q;

endmodule
